@@ rtl/scd_pkg.sv @@
// ----------------------------------------------------------------------------
// Scancode decoder package
// Shared types, scancode constants and the key ROM for the set-1 decoder.
// ----------------------------------------------------------------------------
package scd_pkg;

  localparam int unsigned CodeW  = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgGameMode = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgKillCode = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgEofCode  = 2'd2;

  localparam logic [CodeW-1:0] ScLShiftMake = 8'h2A;
  localparam logic [CodeW-1:0] ScRShiftMake = 8'h36;
  localparam logic [CodeW-1:0] ScCapsMake   = 8'h3A;
  localparam logic [CodeW-1:0] ScCtrlMake   = 8'h1D;
  localparam logic [CodeW-1:0] ScKillKey    = 8'h2E;
  localparam logic [CodeW-1:0] ScEofKey     = 8'h20;
  localparam logic [CodeW-1:0] ScKeyCount   = 8'h53;
  localparam logic [CodeW-1:0] ScBreakFirst = 8'h81;
  localparam logic [CodeW-1:0] ScLShiftBrk  = 8'hAA;
  localparam logic [CodeW-1:0] ScRShiftBrk  = 8'hB6;
  localparam logic [CodeW-1:0] ScCtrlBrk    = 8'h9D;

  localparam logic [CodeW-1:0] KillCodeRst  = 8'd3;
  localparam logic [CodeW-1:0] EofCodeRst   = 8'd255;

  typedef struct packed {
    logic shift;
    logic caps;
    logic ctrl;
  } mods_t;

  typedef struct packed {
    logic             game_mode;
    logic [CodeW-1:0] kill_code;
    logic [CodeW-1:0] eof_code;
  } cfg_t;

  typedef struct packed {
    logic             key_down;
    logic             char_valid;
    logic [CodeW-1:0] char_code;
    logic             to_game;
  } result_t;

  function automatic logic [CodeW-1:0] rom_plain(input logic [6:0] idx);
    logic [CodeW-1:0] c;
    begin
      case (idx)
        7'h01: c = 8'h1B;
        7'h02: c = 8'h31;
        7'h03: c = 8'h32;
        7'h04: c = 8'h33;
        7'h05: c = 8'h34;
        7'h06: c = 8'h35;
        7'h07: c = 8'h36;
        7'h08: c = 8'h37;
        7'h09: c = 8'h38;
        7'h0A: c = 8'h39;
        7'h0B: c = 8'h30;
        7'h0C: c = 8'h2D;
        7'h0D: c = 8'h3D;
        7'h0E: c = 8'h08;
        7'h0F: c = 8'h09;
        7'h10: c = 8'h71;
        7'h11: c = 8'h77;
        7'h12: c = 8'h65;
        7'h13: c = 8'h72;
        7'h14: c = 8'h74;
        7'h15: c = 8'h79;
        7'h16: c = 8'h75;
        7'h17: c = 8'h69;
        7'h18: c = 8'h6F;
        7'h19: c = 8'h70;
        7'h1A: c = 8'h5B;
        7'h1B: c = 8'h5D;
        7'h1C: c = 8'h0A;
        7'h1E: c = 8'h61;
        7'h1F: c = 8'h73;
        7'h20: c = 8'h64;
        7'h21: c = 8'h66;
        7'h22: c = 8'h67;
        7'h23: c = 8'h68;
        7'h24: c = 8'h6A;
        7'h25: c = 8'h6B;
        7'h26: c = 8'h6C;
        7'h27: c = 8'h3B;
        7'h28: c = 8'h27;
        7'h29: c = 8'h60;
        7'h2B: c = 8'h5C;
        7'h2C: c = 8'h7A;
        7'h2D: c = 8'h78;
        7'h2E: c = 8'h63;
        7'h2F: c = 8'h76;
        7'h30: c = 8'h62;
        7'h31: c = 8'h6E;
        7'h32: c = 8'h6D;
        7'h33: c = 8'h2C;
        7'h34: c = 8'h2E;
        7'h35: c = 8'h2F;
        7'h37: c = 8'h2A;
        7'h39: c = 8'h20;
        7'h48: c = 8'd17;
        7'h4B: c = 8'd18;
        7'h4D: c = 8'd19;
        7'h50: c = 8'd20;
        default: c = 8'h00;
      endcase
      return c;
    end
  endfunction

  // The shifted row differs from the plain row only in digits, punctuation and letters.
  function automatic logic [CodeW-1:0] rom_shift(input logic [6:0] idx);
    logic [CodeW-1:0] p;
    logic [CodeW-1:0] c;
    begin
      p = rom_plain(idx);
      case (idx)
        7'h02: c = 8'h21;
        7'h03: c = 8'h40;
        7'h04: c = 8'h23;
        7'h05: c = 8'h24;
        7'h06: c = 8'h25;
        7'h07: c = 8'h5E;
        7'h08: c = 8'h26;
        7'h09: c = 8'h2A;
        7'h0A: c = 8'h28;
        7'h0B: c = 8'h29;
        7'h0C: c = 8'h5F;
        7'h0D: c = 8'h2B;
        7'h1A: c = 8'h7B;
        7'h1B: c = 8'h7D;
        7'h27: c = 8'h3A;
        7'h28: c = 8'h22;
        7'h29: c = 8'h7C;
        7'h33: c = 8'h3C;
        7'h34: c = 8'h3E;
        7'h35: c = 8'h3F;
        default: begin
          if (p inside {[8'h61:8'h7A]}) begin
            c = p - 8'd32;
          end else begin
            c = p;
          end
        end
      endcase
      return c;
    end
  endfunction

endpackage

@@ rtl/scd_decode.sv @@
// ----------------------------------------------------------------------------
// Scancode decode logic
// Turns one scancode and the current modifier state into a result and the
// next modifier state.
// ----------------------------------------------------------------------------
module scd_decode (
  input  logic [scd_pkg::CodeW-1:0] scancode_i,
  input  scd_pkg::mods_t            mods_i,
  input  scd_pkg::cfg_t             cfg_i,
  output scd_pkg::mods_t            mods_o,
  output scd_pkg::result_t          result_o
);

  logic                      down;
  logic                      valid;
  logic [scd_pkg::CodeW-1:0] ch;
  logic [scd_pkg::CodeW-1:0] rom_ch;
  logic [6:0]                idx;

  assign idx = scancode_i[6:0];

  always_comb begin
    if (mods_i.shift) begin
      rom_ch = scd_pkg::rom_shift(idx);
      if (mods_i.caps && (rom_ch inside {[8'h41:8'h5A]})) begin
        rom_ch = rom_ch + 8'd32;
      end
    end else begin
      rom_ch = scd_pkg::rom_plain(idx);
      if (mods_i.caps && (rom_ch inside {[8'h61:8'h7A]})) begin
        rom_ch = rom_ch - 8'd32;
      end
    end
  end

  always_comb begin
    down   = scancode_i < scd_pkg::ScBreakFirst;
    valid  = 1'b0;
    ch     = '0;
    mods_o = mods_i;
    if (down) begin
      if ((scancode_i == scd_pkg::ScLShiftMake) || (scancode_i == scd_pkg::ScRShiftMake)) begin
        mods_o.shift = 1'b1;
      end else if (scancode_i == scd_pkg::ScCapsMake) begin
        mods_o.caps = ~mods_i.caps;
      end else if (scancode_i == scd_pkg::ScCtrlMake) begin
        mods_o.ctrl = 1'b1;
      end else if (scancode_i < scd_pkg::ScKeyCount) begin
        if (mods_i.ctrl) begin
          if (scancode_i == scd_pkg::ScKillKey) begin
            ch    = cfg_i.kill_code;
            valid = 1'b1;
          end else if (scancode_i == scd_pkg::ScEofKey) begin
            ch    = cfg_i.eof_code;
            valid = 1'b1;
          end
        end else begin
          ch    = rom_ch;
          valid = 1'b1;
        end
        if (valid && !cfg_i.game_mode && (ch inside {[8'd17:8'd20]})) begin
          valid = 1'b0;
        end
      end
    end else begin
      if ((scancode_i == scd_pkg::ScLShiftBrk) || (scancode_i == scd_pkg::ScRShiftBrk)) begin
        mods_o.shift = 1'b0;
      end else if (scancode_i == scd_pkg::ScCtrlBrk) begin
        mods_o.ctrl = 1'b0;
      end
    end

    result_o.key_down   = down;
    result_o.char_valid = valid;
    result_o.char_code  = valid ? ch : '0;
    result_o.to_game    = valid && cfg_i.game_mode;
  end

endmodule

@@ rtl/scancode_to_ascii_decoder.sv @@
// ----------------------------------------------------------------------------
// Set-1 scancode to ASCII decoder
// The scancode is registered in the input stage, decoded, and the result is
// registered in the output stage. Throughput is one item per cycle when the
// output is not stalled. Reset clears the modifier flags and the valid flags
// of both pipeline stages and loads the config registers with their defaults.
// ----------------------------------------------------------------------------
module scancode_to_ascii_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [scd_pkg::CodeW-1:0]   scancode_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        key_down_o,
  output logic                        char_valid_o,
  output logic [scd_pkg::CodeW-1:0]   char_code_o,
  output logic                        to_game_o,
  input  logic                        cfg_we_i,
  input  logic [scd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [scd_pkg::CodeW-1:0]   cfg_data_i
);

  logic                      in_valid_q;
  logic [scd_pkg::CodeW-1:0] code_q;
  logic                      out_valid_q;
  scd_pkg::result_t          res_q;
  scd_pkg::result_t          res_d;
  scd_pkg::mods_t            mods_q;
  scd_pkg::mods_t            mods_d;
  scd_pkg::cfg_t             cfg_q;
  logic                      out_free;
  logic                      advance;
  logic                      in_accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  scd_decode u_decode (
    .scancode_i (code_q),
    .mods_i     (mods_q),
    .cfg_i      (cfg_q),
    .mods_o     (mods_d),
    .result_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mods_q      <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        mods_q <= mods_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      code_q <= scancode_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.game_mode <= 1'b0;
      cfg_q.kill_code <= scd_pkg::KillCodeRst;
      cfg_q.eof_code  <= scd_pkg::EofCodeRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        scd_pkg::CfgGameMode: cfg_q.game_mode <= cfg_data_i[0];
        scd_pkg::CfgKillCode: cfg_q.kill_code <= cfg_data_i;
        scd_pkg::CfgEofCode:  cfg_q.eof_code  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign key_down_o   = res_q.key_down;
  assign char_valid_o = res_q.char_valid;
  assign char_code_o  = res_q.char_code;
  assign to_game_o    = res_q.to_game;

endmodule

@@ tb/sv/scancode_to_ascii_decoder_test.sv @@
// ----------------------------------------------------------------------------
// Scancode decoder regression
// Drives set-1 scancodes into the decoder under random input gaps and output
// stalls, predicts each result from a behavioural copy of the modifier and
// key ROM logic, and compares every result field by field in order. The run
// moves through several register settings, including the extremes.
// ----------------------------------------------------------------------------

class keystroke_tracker;

  localparam logic [7:0] ArrowFirst = 8'd17;
  localparam logic [7:0] ArrowLast  = 8'd20;
  localparam logic [7:0] CaseOffset = 8'd32;

  logic [7:0] key_plain [83];
  logic [7:0] key_shift [83];

  logic       shift_down;
  logic       caps_on;
  logic       ctrl_down;
  logic       game_sel;
  logic [7:0] kill_char;
  logic [7:0] eof_char;

  scd_pkg::result_t expected_decodes [$];

  int n_codes;
  int n_checked;
  int n_chars;
  int n_game;
  int n_errors;

  function new();
    key_plain = '{
      8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
      8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68,
      8'h6A, 8'h6B, 8'h6C, 8'h3B, 8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
      8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h11, 8'h00, 8'h00, 8'h12, 8'h00, 8'h13, 8'h00, 8'h00, 8'h14, 8'h00, 8'h00};
    key_shift = '{
      8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29,
      8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48,
      8'h4A, 8'h4B, 8'h4C, 8'h3A, 8'h22, 8'h7C, 8'h00, 8'h5C, 8'h5A, 8'h58, 8'h43, 8'h56,
      8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h11, 8'h00, 8'h00, 8'h12, 8'h00, 8'h13, 8'h00, 8'h00, 8'h14, 8'h00, 8'h00};
    shift_down = 1'b0;
    caps_on    = 1'b0;
    ctrl_down  = 1'b0;
    game_sel   = 1'b0;
    kill_char  = scd_pkg::KillCodeRst;
    eof_char   = scd_pkg::EofCodeRst;
    n_codes    = 0;
    n_checked  = 0;
    n_chars    = 0;
    n_game     = 0;
    n_errors   = 0;
  endfunction

  function void set_register(logic [scd_pkg::CfgIdxW-1:0] idx, logic [7:0] data);
    case (idx)
      scd_pkg::CfgGameMode: game_sel = data[0];
      scd_pkg::CfgKillCode: kill_char = data;
      scd_pkg::CfgEofCode:  eof_char = data;
      default: ;
    endcase
  endfunction

  function logic [7:0] key_char(logic [6:0] idx);
    logic [7:0] c;
    if (shift_down) begin
      c = key_shift[idx];
      if (caps_on && c >= "A" && c <= "Z") begin
        c = c + CaseOffset;
      end
    end else begin
      c = key_plain[idx];
      if (caps_on && c >= "a" && c <= "z") begin
        c = c - CaseOffset;
      end
    end
    return c;
  endfunction

  function void note_scancode(logic [7:0] code);
    scd_pkg::result_t r;
    logic [7:0]       ch;
    logic             ok;
    ch = 8'h00;
    ok = 1'b0;
    r  = '0;
    r.key_down = (code < scd_pkg::ScBreakFirst);
    if (r.key_down) begin
      case (code)
        scd_pkg::ScLShiftMake, scd_pkg::ScRShiftMake: shift_down = 1'b1;
        scd_pkg::ScCapsMake: caps_on = ~caps_on;
        scd_pkg::ScCtrlMake: ctrl_down = 1'b1;
        default: begin
          if (code < scd_pkg::ScKeyCount) begin
            if (ctrl_down) begin
              if (code == scd_pkg::ScKillKey) begin
                ch = kill_char;
                ok = 1'b1;
              end else if (code == scd_pkg::ScEofKey) begin
                ch = eof_char;
                ok = 1'b1;
              end
            end else begin
              ch = key_char(code[6:0]);
              ok = 1'b1;
            end
            if (ok && !game_sel && ch >= ArrowFirst && ch <= ArrowLast) begin
              ok = 1'b0;
            end
          end
        end
      endcase
    end else begin
      if (code == scd_pkg::ScLShiftBrk || code == scd_pkg::ScRShiftBrk) begin
        shift_down = 1'b0;
      end else if (code == scd_pkg::ScCtrlBrk) begin
        ctrl_down = 1'b0;
      end
    end
    r.char_valid = ok;
    r.char_code  = ok ? ch : 8'h00;
    r.to_game    = ok & game_sel;
    expected_decodes.push_back(r);
    n_codes++;
  endfunction

  function void compare_field(string field, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  function void check_result(logic key_down, logic char_valid, logic [7:0] char_code,
                             logic to_game);
    scd_pkg::result_t want;
    if (expected_decodes.size() == 0) begin
      n_errors++;
      $display("%0t: result with none expected, expected nothing, actual %0h/%0h/%0h/%0h",
               $time, key_down, char_valid, char_code, to_game);
      return;
    end
    want = expected_decodes.pop_front();
    compare_field("key_down", 8'(want.key_down), 8'(key_down));
    compare_field("char_valid", 8'(want.char_valid), 8'(char_valid));
    compare_field("char_code", want.char_code, char_code);
    compare_field("to_game", 8'(want.to_game), 8'(to_game));
    n_checked++;
    if (want.char_valid) begin
      n_chars++;
    end
    if (want.to_game) begin
      n_game++;
    end
  endfunction

  function int pending_count();
    return expected_decodes.size();
  endfunction

endclass

module scancode_to_ascii_decoder_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CycleLimit    = 400000;
  localparam int         PhaseCount    = 8;
  localparam int         ItemsPerPhase = 205;
  localparam int         SettleCycles  = 6;
  localparam logic [7:0] BreakFlag     = 8'h80;

  typedef enum logic [1:0] {
    StallNone,
    StallLight,
    StallHeavy,
    StallToggle
  } stall_style_e;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [scd_pkg::CodeW-1:0]   scancode_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic                        key_down_o;
  logic                        char_valid_o;
  logic [scd_pkg::CodeW-1:0]   char_code_o;
  logic                        to_game_o;
  logic                        cfg_we_i = 1'b0;
  logic [scd_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [scd_pkg::CodeW-1:0]   cfg_data_i = '0;

  keystroke_tracker tracker = new();
  logic [7:0]       scancode_plan [$];
  stall_style_e     stall_style = StallNone;
  int               style_cycles = 0;
  int               cycle_count = 0;
  int               settings_used = 1;

  scancode_to_ascii_decoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .scancode_i   (scancode_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .key_down_o   (key_down_o),
    .char_valid_o (char_valid_o),
    .char_code_o  (char_code_o),
    .to_game_o    (to_game_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      tracker.note_scancode(scancode_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.check_result(key_down_o, char_valid_o, char_code_o, to_game_o);
    end
  end

  always @(posedge clk_i) begin
    if (style_cycles == 0) begin
      stall_style  <= stall_style_e'($urandom_range(3, 0));
      style_cycles <= $urandom_range(400, 40);
    end else begin
      style_cycles <= style_cycles - 1;
    end
    case (stall_style)
      StallNone:  out_stall_i <= 1'b0;
      StallLight: out_stall_i <= ($urandom_range(7, 0) == 0);
      StallHeavy: out_stall_i <= ($urandom_range(3, 0) != 0);
      default:    out_stall_i <= ~out_stall_i;
    endcase
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("scancode_to_ascii_decoder regression: fail");
      $finish;
    end
  end

  task automatic send_code(input logic [7:0] code);
    in_valid_i <= 1'b1;
    scancode_i <= code;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
  endtask

  task automatic play_codes();
    int burst;
    int gap;
    burst = 0;
    while (scancode_plan.size() != 0) begin
      if (burst == 0) begin
        burst = ($urandom_range(4, 0) == 0) ? $urandom_range(120, 40) : $urandom_range(12, 1);
      end
      send_code(scancode_plan.pop_front());
      burst--;
      if (burst == 0 && scancode_plan.size() != 0) begin
        gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    @(posedge clk_i);
    while (tracker.pending_count() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic game, input logic [7:0] kill,
                                input logic [7:0] eof);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= scd_pkg::CfgGameMode;
    cfg_data_i  <= {7'($urandom_range(127, 0)), game};
    @(posedge clk_i);
    cfg_index_i <= scd_pkg::CfgKillCode;
    cfg_data_i  <= kill;
    @(posedge clk_i);
    cfg_index_i <= scd_pkg::CfgEofCode;
    cfg_data_i  <= eof;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_register(scd_pkg::CfgGameMode, {7'd0, game});
    tracker.set_register(scd_pkg::CfgKillCode, kill);
    tracker.set_register(scd_pkg::CfgEofCode, eof);
    settings_used++;
  endtask

  task automatic add_keystroke(input logic [7:0] key);
    scancode_plan.push_back(key);
    scancode_plan.push_back(key | BreakFlag);
  endtask

  task automatic build_random_codes(input int count);
    int         sel;
    int         n;
    logic [7:0] key;
    scancode_plan.push_back(scd_pkg::ScCtrlBrk);
    scancode_plan.push_back(scd_pkg::ScLShiftBrk);
    while (scancode_plan.size() < count) begin
      sel = $urandom_range(99, 0);
      if (sel < 50) begin
        add_keystroke(8'($urandom_range(scd_pkg::ScKeyCount - 1, 0)));
      end else if (sel < 64) begin
        scancode_plan.push_back($urandom_range(1, 0) ? scd_pkg::ScLShiftMake
                                                     : scd_pkg::ScRShiftMake);
        n = $urandom_range(4, 1);
        repeat (n) add_keystroke(8'($urandom_range(scd_pkg::ScKeyCount - 1, 0)));
        scancode_plan.push_back($urandom_range(1, 0) ? scd_pkg::ScLShiftBrk
                                                     : scd_pkg::ScRShiftBrk);
      end else if (sel < 71) begin
        add_keystroke(scd_pkg::ScCapsMake);
      end else if (sel < 84) begin
        scancode_plan.push_back(scd_pkg::ScCtrlMake);
        case ($urandom_range(2, 0))
          0:       key = scd_pkg::ScKillKey;
          1:       key = scd_pkg::ScEofKey;
          default: key = 8'($urandom_range(scd_pkg::ScKeyCount - 1, 0));
        endcase
        add_keystroke(key);
        scancode_plan.push_back(scd_pkg::ScCtrlBrk);
      end else begin
        scancode_plan.push_back(8'($urandom_range(255, 0)));
      end
    end
  endtask

  initial begin
    logic       game;
    logic [7:0] kill;
    logic [7:0] eof;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: empty entry, caps and shift together, ctrl keys, arrows dropped.
    scancode_plan = '{8'h00, 8'h10, scd_pkg::ScCapsMake, 8'h10, scd_pkg::ScLShiftMake,
                      8'h10, 8'h02, scd_pkg::ScLShiftBrk, scd_pkg::ScCapsMake,
                      scd_pkg::ScRShiftMake, 8'h1E, scd_pkg::ScRShiftBrk,
                      scd_pkg::ScCtrlMake, scd_pkg::ScKillKey, scd_pkg::ScEofKey, 8'h10,
                      scd_pkg::ScCtrlBrk, 8'h48, 8'h52, scd_pkg::ScKeyCount, 8'h80,
                      scd_pkg::ScBreakFirst, 8'hFF, 8'h7F};
    play_codes();
    wait_idle();

    for (int phase = 1; phase <= PhaseCount; phase++) begin
      case (phase)
        1: begin
          game = 1'b1;
          kill = 8'h00;
          eof  = 8'h00;
        end
        2: begin
          game = 1'b0;
          kill = 8'hFF;
          eof  = 8'h00;
        end
        3: begin
          game = 1'b1;
          kill = 8'd17;
          eof  = 8'd20;
        end
        4: begin
          game = 1'b0;
          kill = 8'd18;
          eof  = 8'd19;
        end
        default: begin
          game = 1'($urandom_range(1, 0));
          kill = ($urandom_range(3, 0) == 0) ? 8'($urandom_range(20, 17))
                                             : 8'($urandom_range(255, 0));
          eof  = 8'($urandom_range(255, 0));
        end
      endcase
      apply_settings(game, kill, eof);
      build_random_codes(ItemsPerPhase);
      play_codes();
      wait_idle();
    end

    $display("Decoded %0d scancodes under %0d register settings with random gaps and stalls.",
             tracker.n_codes, settings_used);
    $display("Checked %0d results: %0d characters, %0d of them routed to the game buffer.",
             tracker.n_checked, tracker.n_chars, tracker.n_game);
    if (tracker.n_errors == 0) begin
      $display("scancode_to_ascii_decoder regression: pass");
    end else begin
      $display("scancode_to_ascii_decoder regression: fail");
    end
    $finish;
  end

endmodule
